@@ hw/rtl/cfws_pkg.sv @@
// Package for the circular FIFO with search: sizes, operation codes and the
// request type passed from the front end to the back end.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cfws_pkg;

	localparam int DEPTH   = 64;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W   = $clog2(DEPTH + 1);
	localparam int COUNT_W = 7;
	localparam int WORD_W  = 32;
	localparam int FUNC_W  = 2;

	localparam logic [FUNC_W-1:0] OP_QUERY = 2'd0;
	localparam logic [FUNC_W-1:0] OP_ENQ   = 2'd1;
	localparam logic [FUNC_W-1:0] OP_DEQ   = 2'd2;
	localparam logic [FUNC_W-1:0] OP_SRCH  = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic [WORD_W-1:0] value;
	} req_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/cfws_front.sv @@
// Front end of the circular FIFO with search: accepts requests and holds
// them in a two-entry queue ahead of the back end.
// Depends on cfws_pkg.
`timescale 1ns / 1ps

module cfws_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cfws_pkg::FUNC_W-1:0]   func,
	input  logic signed [cfws_pkg::WORD_W-1:0] value,
	output logic                          req_valid,
	input  logic                          req_ready,
	output cfws_pkg::req_t                req
);
	import cfws_pkg::*;

	req_t       entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign req_valid = (cnt_q != 2'd0);
	assign req       = entry_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q].op    <= func;
			entry_q[wr_q].value <= value;
		end
	end

endmodule

@@ hw/rtl/cfws_back.sv @@
// Back end of the circular FIFO with search: the word store, its pointers,
// the search walk and the result register.
// Depends on cfws_pkg.
`timescale 1ns / 1ps

module cfws_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  cfws_pkg::req_t                     req,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               ok,
	output logic signed [cfws_pkg::WORD_W-1:0] popped,
	output logic                               found,
	output logic signed [cfws_pkg::WORD_W-1:0] head_value,
	output logic signed [cfws_pkg::WORD_W-1:0] tail_value,
	output logic [cfws_pkg::COUNT_W-1:0]       count
);
	import cfws_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DEQ  = 2'd1;
	localparam logic [1:0] ST_SRCH = 2'd2;

	logic [WORD_W-1:0]  mem [DEPTH];
	logic [WORD_W-1:0]  rdata_q;
	logic [PTR_W-1:0]   rd_addr;
	logic               mem_we;

	logic [1:0]         state_q, state_d;
	logic [PTR_W-1:0]   head_q, head_d;
	logic [PTR_W-1:0]   tail_q, tail_d;
	logic [OCC_W-1:0]   occ_q, occ_d;
	logic [WORD_W-1:0]  head_word_q, head_word_d;
	logic [WORD_W-1:0]  tail_word_q, tail_word_d;
	logic [PTR_W-1:0]   p_q, p_d;
	logic [OCC_W-1:0]   left_q, left_d;
	logic [WORD_W-1:0]  key_q, key_d;
	logic               rd_pend_q, rd_pend_d;

	logic               out_valid_q, out_valid_d;
	logic               ok_q, ok_d;
	logic [WORD_W-1:0]  popped_q, popped_d;
	logic               found_q, found_d;
	logic [WORD_W-1:0]  headv_q, headv_d;
	logic [WORD_W-1:0]  tailv_q, tailv_d;
	logic [COUNT_W-1:0] count_q, count_d;

	logic               slot_free;
	logic               take;
	logic               full;
	logic               empty;
	logic               hit;
	logic               emit;

	assign slot_free = !out_valid_q || out_ready;
	assign req_ready = (state_q == ST_IDLE) && slot_free;
	assign take      = req_valid && req_ready;
	assign full      = (occ_q == OCC_W'(DEPTH));
	assign empty     = (occ_q == '0);
	assign hit       = rd_pend_q && (rdata_q == key_q);
	assign rd_addr   = (state_q == ST_IDLE) ? ptr_next(head_q) : p_q;

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		occ_d       = occ_q;
		head_word_d = head_word_q;
		tail_word_d = tail_word_q;
		p_d         = p_q;
		left_d      = left_q;
		key_d       = key_q;
		rd_pend_d   = 1'b0;
		mem_we      = 1'b0;
		emit        = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		ok_d        = ok_q;
		popped_d    = popped_q;
		found_d     = found_q;
		headv_d     = headv_q;
		tailv_d     = tailv_q;
		count_d     = count_q;

		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					ok_d     = 1'b1;
					popped_d = '0;
					found_d  = 1'b0;
					unique case (req.op)
						OP_ENQ: begin
							emit = 1'b1;
							if (full) begin
								ok_d = 1'b0;
							end else begin
								mem_we      = 1'b1;
								tail_d      = ptr_next(tail_q);
								occ_d       = occ_q + 1'b1;
								tail_word_d = req.value;
								if (empty) begin
									head_word_d = req.value;
								end
							end
						end
						OP_DEQ: begin
							if (empty) begin
								ok_d = 1'b0;
								emit = 1'b1;
							end else begin
								popped_d = head_word_q;
								head_d   = ptr_next(head_q);
								occ_d    = occ_q - 1'b1;
								if (occ_q == OCC_W'(1)) begin
									emit = 1'b1;
								end else begin
									state_d = ST_DEQ;
								end
							end
						end
						OP_SRCH: begin
							if (empty) begin
								emit = 1'b1;
							end else begin
								state_d = ST_SRCH;
								p_d     = head_q;
								left_d  = occ_q;
								key_d   = req.value;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			ST_DEQ: begin
				head_word_d = rdata_q;
				emit        = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_SRCH: begin
				if (hit || left_q == '0) begin
					found_d = hit;
					emit    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					p_d       = ptr_next(p_q);
					left_d    = left_q - 1'b1;
					rd_pend_d = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (emit) begin
			out_valid_d = 1'b1;
			headv_d     = (occ_d == '0) ? '1 : head_word_d;
			tailv_d     = (occ_d == '0) ? '1 : tail_word_d;
			count_d     = COUNT_W'(occ_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			occ_q       <= occ_d;
			rd_pend_q   <= rd_pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		head_word_q <= head_word_d;
		tail_word_q <= tail_word_d;
		p_q         <= p_d;
		left_q      <= left_d;
		key_q       <= key_d;
		ok_q        <= ok_d;
		popped_q    <= popped_d;
		found_q     <= found_d;
		headv_q     <= headv_d;
		tailv_q     <= tailv_d;
		count_q     <= count_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= req.value;
		end
		rdata_q <= mem[rd_addr];
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign popped     = popped_q;
	assign found      = found_q;
	assign head_value = headv_q;
	assign tail_value = tailv_q;
	assign count      = count_q;

endmodule

@@ hw/rtl/circular_fifo_with_search.sv @@
// Top level of the circular FIFO with search: joins the request queue and
// the back end that owns the store.
// Depends on cfws_pkg, cfws_front and cfws_back.
`timescale 1ns / 1ps

// The block holds up to 64 signed 32-bit words in a circular store and
// answers one result per request. A request waits at most two deep in the
// input queue, so the input side keeps taking requests while the back end
// is busy. In the back end, query, enqueue and refused requests are answered
// straight from the idle state, a dequeue that leaves the FIFO non-empty also
// passes through a state that reloads the head word, and a search walks the
// store, since the store has a single registered read port and the walk reads
// one entry per cycle from the oldest word onward, stopping at the first
// match. The result register holds a result until it is taken, and the next
// request starts as soon as that register is free.

module circular_fifo_with_search (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [cfws_pkg::FUNC_W-1:0]        func,
	input  logic signed [cfws_pkg::WORD_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               ok,
	output logic signed [cfws_pkg::WORD_W-1:0] popped,
	output logic                               found,
	output logic signed [cfws_pkg::WORD_W-1:0] head_value,
	output logic signed [cfws_pkg::WORD_W-1:0] tail_value,
	output logic [cfws_pkg::COUNT_W-1:0]       count
);
	import cfws_pkg::*;

	logic req_valid;
	logic req_ready;
	req_t req;

	cfws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req)
	);

	cfws_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.popped     (popped),
		.found      (found),
		.head_value (head_value),
		.tail_value (tail_value),
		.count      (count)
	);

endmodule

@@ hw/rtl/cfws_check.sv @@
// Port checker for the circular FIFO with search, and the bind that
// attaches it to the top level.
// Depends on cfws_pkg and circular_fifo_with_search.
`timescale 1ns / 1ps

module cfws_check (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic [cfws_pkg::FUNC_W-1:0]        func,
	input logic signed [cfws_pkg::WORD_W-1:0] value,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               ok,
	input logic signed [cfws_pkg::WORD_W-1:0] popped,
	input logic                               found,
	input logic signed [cfws_pkg::WORD_W-1:0] head_value,
	input logic signed [cfws_pkg::WORD_W-1:0] tail_value,
	input logic [cfws_pkg::COUNT_W-1:0]       count
);
	import cfws_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(count))
		else $error("A stalled result changed or vanished.");

	a_refused_pops_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> popped == '0)
		else $error("A refused request reported a popped word.");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> ok && popped == '0)
		else $error("A search hit came with a bad status.");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count == '0 |-> head_value == '1 && tail_value == '1)
		else $error("An empty FIFO reported a stored word.");

endmodule

bind circular_fifo_with_search cfws_check u_cfws_check (.*);
